>>> hdl/tfrs_pkg.sv
`default_nettype none

package tfrs_pkg;

    localparam int STAMP_W = 48;
    localparam int DIM_W   = 16;
    localparam int ID_W    = 32;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_BEFORE = 2'd1;
    localparam logic [OP_W-1:0] OP_AFTER  = 2'd2;
    localparam logic [OP_W-1:0] OP_LATEST = 2'd3;

    // depth of the queue between the front and the engine
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_BEFORE = 2'd1,
        KIND_AFTER  = 2'd2,
        KIND_LATEST = 2'd3
    } kind_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [STAMP_W-1:0] stamp;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    match_id;
        logic [STAMP_W-1:0] match_stamp;
        logic [DIM_W-1:0]   match_width;
        logic [DIM_W-1:0]   match_height;
        logic [ID_W-1:0]    frames_written;
    } result_t;

    typedef struct packed {
        kind_t              kind;
        logic [STAMP_W-1:0] stamp;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } cmd_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } slot_t;

endpackage

`default_nettype wire

>>> hdl/tfrs_front.sv
`default_nettype none

module tfrs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tfrs_pkg::request_t request,
    output logic                   cmd_valid,
    output tfrs_pkg::cmd_t         cmd,
    input  wire logic              cmd_take
);

    tfrs_pkg::cmd_t                       entry_reg [tfrs_pkg::CMDQ_DEPTH];
    logic [tfrs_pkg::CMDQ_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tfrs_pkg::CMDQ_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tfrs_pkg::CMDQ_CNT_W-1:0]      cnt_reg, cnt_next;
    tfrs_pkg::cmd_t                       classified;
    logic                                 do_push;
    logic                                 do_pop;

    // classify the operation code into a command kind
    always_comb
    begin
        classified.stamp        = request.stamp;
        classified.frame_width  = request.frame_width;
        classified.frame_height = request.frame_height;
        unique case (request.operation)
            tfrs_pkg::OP_WRITE:  classified.kind = tfrs_pkg::KIND_WRITE;
            tfrs_pkg::OP_BEFORE: classified.kind = tfrs_pkg::KIND_BEFORE;
            tfrs_pkg::OP_AFTER:  classified.kind = tfrs_pkg::KIND_AFTER;
            default:             classified.kind = tfrs_pkg::KIND_LATEST;
        endcase
    end

    assign full      = (cnt_reg == tfrs_pkg::CMDQ_CNT_W'(tfrs_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tfrs_engine.sv
`default_nettype none

module tfrs_engine #(
    parameter int SLOTS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire tfrs_pkg::cmd_t  cmd,
    output logic                 cmd_take,
    input  wire logic            pop,
    output logic                 empty,
    output tfrs_pkg::result_t    result
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    tfrs_pkg::slot_t                mem [SLOTS];
    tfrs_pkg::slot_t                rd_data_reg;
    logic                           rd_pend_reg;
    tfrs_pkg::slot_t                best_reg;
    logic                           have_reg;
    tfrs_pkg::kind_t                kind_reg;
    logic [tfrs_pkg::STAMP_W-1:0]   target_reg;
    logic [IDX_W-1:0]               head_reg;
    logic [IDX_W-1:0]               scan_idx_reg;
    logic [CNT_W-1:0]               fill_reg;
    logic [tfrs_pkg::ID_W-1:0]      count_reg;
    logic [tfrs_pkg::ID_W-1:0]      new_id;
    logic                           out_valid_reg;
    tfrs_pkg::result_t              out_item_reg;
    tfrs_pkg::result_t              res;
    tfrs_pkg::slot_t                new_slot;
    logic                           do_write;
    logic                           scan_last;
    logic                           better;
    logic                           out_load;

    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
    assign do_write  = cmd_take && (cmd.kind == tfrs_pkg::KIND_WRITE);
    assign new_id    = count_reg + tfrs_pkg::ID_W'(1);
    assign scan_last = (CNT_W'(scan_idx_reg) == fill_reg - CNT_W'(1));
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || pop);
    assign empty     = !out_valid_reg;
    assign result    = out_item_reg;

    always_comb
    begin
        new_slot.stamp        = cmd.stamp;
        new_slot.id           = new_id;
        new_slot.frame_width  = cmd.frame_width;
        new_slot.frame_height = cmd.frame_height;
    end

    // strict compares in ascending slot order keep the lowest index on ties
    always_comb
    begin
        case (kind_reg)
            tfrs_pkg::KIND_BEFORE:
                better = (rd_data_reg.stamp <= target_reg)
                      && (!have_reg || rd_data_reg.stamp > best_reg.stamp);
            tfrs_pkg::KIND_AFTER:
                better = (rd_data_reg.stamp >= target_reg)
                      && (!have_reg || rd_data_reg.stamp < best_reg.stamp);
            tfrs_pkg::KIND_LATEST:
                better = (rd_data_reg.stamp > best_reg.stamp);
            default:
                better = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == tfrs_pkg::KIND_WRITE || fill_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.frames_written = count_reg;
        unique case (kind_reg)
            tfrs_pkg::KIND_LATEST:
            begin
                res.found        = (fill_reg != '0);
                res.match_id     = '0;
                res.match_stamp  = best_reg.stamp;
                res.match_width  = '0;
                res.match_height = '0;
            end
            default:
            begin
                res.found        = have_reg;
                res.match_id     = best_reg.id;
                res.match_stamp  = best_reg.stamp;
                res.match_width  = best_reg.frame_width;
                res.match_height = best_reg.frame_height;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            have_reg      <= 1'b0;
            head_reg      <= '0;
            scan_idx_reg  <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            if (cmd_take)
            begin
                have_reg     <= do_write;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (rd_pend_reg && better)
                begin
                    have_reg <= 1'b1;
                end
                if (state_reg == ST_SCAN)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            if (do_write)
            begin
                head_reg  <= (head_reg == IDX_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
                fill_reg  <= (fill_reg == CNT_W'(SLOTS)) ? fill_reg : fill_reg + 1'b1;
                count_reg <= new_id;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // descriptor ring: one write port at the head, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[head_reg] <= new_slot;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            kind_reg   <= cmd.kind;
            target_reg <= cmd.stamp;
            best_reg   <= do_write ? new_slot : '0;
        end
        else if (rd_pend_reg && better)
        begin
            best_reg <= rd_data_reg;
        end
        if (out_load)
        begin
            out_item_reg <= res;
        end
    end

endmodule

`default_nettype wire

>>> hdl/timestamped_frame_ring_search.sv
// timestamped frame ring search
// input channel: request (operation, stamp, frame_width, frame_height), taken when
//   push is high and full is low; a two-entry queue decouples it from the engine
// result channel: result is valid while empty is low and is taken when pop is high
// a write stores the frame at the head slot of a ring of SLOTS descriptors and
//   returns its sequence number; queries scan the written slots one per cycle
//   through a single registered read port of the descriptor memory
// a write, or a query on an empty ring, goes from idle straight to the emit state;
//   a query scans the fill written slots (fill at most SLOTS), then drains the last
//   registered read, then emits; emit loads the result into the output register
//   once that register is free or is being popped
// the engine takes a new item only in idle, after the last result has loaded
// a finished result waits in the output register; while pop stays low the engine
//   holds the next result and the front queue keeps taking items until full
// reset empties both queues, marks every slot unwritten, sets the head to slot
//   zero and the frame count to zero; no clearing pass is needed
`default_nettype none

module timestamped_frame_ring_search #(
    parameter int SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire tfrs_pkg::request_t request,
    input  wire logic               pop,
    output logic                    empty,
    output tfrs_pkg::result_t       result
);

    logic           cmd_valid;
    logic           cmd_take;
    tfrs_pkg::cmd_t cmd;

    tfrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tfrs_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("engine took a command from an empty queue");

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd_take)
        else $error("engine took two commands in a row");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.found) |-> (result.match_id == '0
            && result.match_stamp == '0 && result.match_width == '0
            && result.match_height == '0))
        else $error("missed query carries nonzero match fields");

endmodule

`default_nettype wire
